/* design/look_at_view_matrix_assert.svh */
// ----------------------------------------------------------------------------
// look_at_view_matrix assertion macros
// concurrent checks on clk with synchronous active-low reset masking
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_ASSERT_SVH

// same-cycle implication
`define LAV_ASSERT_IMPL(name, cond, impl, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (impl)) \
    else $error(msg);

// next-cycle implication
`define LAV_ASSERT_NEXT(name, cond, impl, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (impl)) \
    else $error(msg);

`endif

/* design/lav_pkg.sv */
// ----------------------------------------------------------------------------
// lav_pkg
// shared constants and fixed-point helpers for the look-at view matrix
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int FIELD_W       = 32;
  localparam int VEC_W         = 64;
  localparam int IN_W          = 9 * FIELD_W;
  localparam int OUT_W         = 12 * FIELD_W;
  localparam int SQRT_STEPS    = 32;
  localparam int FRAME_LAT     = 6;
  localparam int CROSS_LAT     = 2;

  typedef logic signed [FIELD_W-1:0] fld_t;
  typedef logic signed [VEC_W-1:0]   wide_t;

  // normalizer depth: front end 5, root 32, divide prep 1, divide frac+1, sign 1
  function automatic int norm_lat(int frac);
    return frac + 40;
  endfunction

  // drop frac fraction bits, half away from zero
  function automatic wide_t round_fx(wide_t x, int frac);
    logic [VEC_W-1:0] m;
    logic [VEC_W-1:0] q;
    m = x[VEC_W-1] ? VEC_W'(-x) : VEC_W'(x);
    q = (m + (VEC_W'(1) << (frac - 1))) >> frac;
    return x[VEC_W-1] ? -$signed(q) : $signed(q);
  endfunction

  function automatic fld_t sat32(wide_t x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[FIELD_W-1:0];
    end
  endfunction

endpackage

/* design/look_at_view_matrix.sv */
// ----------------------------------------------------------------------------
// look_at_view_matrix
// look-at view matrix rows and translation from target, eye and up, Q16.16
// ----------------------------------------------------------------------------
// channel | dir | tdata                                  | bits
// in_     | in  | target xyz, eye xyz, up_in xyz         | 288
// out_    | out | side xyz, true_up xyz, back xyz, shift | 384
//
// one transfer accepted per cycle while the output is not stalled, one result per transfer
// pipeline depth is dominated by two normalizers that resolve one root bit and one
// quotient bit per stage
// reset clears the valid bits only
// a stalled output freezes every stage at once; nothing is dropped or repeated
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_assert.svh"

module look_at_view_matrix #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // target_x, target_y, target_z, eye_x, eye_y, eye_z, up_in_x, up_in_y, up_in_z
  input  logic [lav_pkg::IN_W-1:0] in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // side_x/y/z, true_up_x/y/z, back_x/y/z, shift_x/y/z
  output logic [lav_pkg::OUT_W-1:0] out_tdata
);

  import lav_pkg::*;

  localparam int FW = FRAC_BITS + 2;
  localparam int NL = norm_lat(FRAC_BITS);
  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

  logic en;

  logic signed [63:0] d0_r [3];
  logic signed [31:0] eye0_r [3];
  logic signed [31:0] up0_r [3];
  logic               v0_r;

  logic                 vf;
  logic signed [FW-1:0] f1 [3];
  logic [95:0]          eye0_flat;
  logic [95:0]          up0_flat;
  logic [95:0]          eye1_flat;
  logic [95:0]          up1_flat;
  logic signed [31:0]   up1 [3];

  logic                 vc;
  logic signed [63:0]   c2 [3];
  logic [3*FW-1:0]      f1_flat;
  logic [3*FW-1:0]      f2_flat;
  logic [95:0]          eye2_flat;

  logic                 vs;
  logic signed [FW-1:0] s3 [3];
  logic [3*FW-1:0]      f3_flat;
  logic [95:0]          eye3_flat;
  logic signed [FW-1:0] f3 [3];
  logic signed [31:0]   eye3 [3];

  logic                 vo;
  logic signed [31:0]   side  [3];
  logic signed [31:0]   tup   [3];
  logic signed [31:0]   back  [3];
  logic signed [31:0]   shift [3];

  logic signed [31:0]   side_x_w;
  logic signed [31:0]   back_x_w;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d0_r[i]   <= 64'($signed(in_tdata[32*i +: 32])) -
                     64'($signed(in_tdata[32*(3+i) +: 32]));
        eye0_r[i] <= $signed(in_tdata[32*(3+i) +: 32]);
        up0_r[i]  <= $signed(in_tdata[32*(6+i) +: 32]);
      end
    end
  end

  lav_norm #(.FRAC(FRAC_BITS)) u_fwd_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (v0_r),
    .v_i   (d0_r),
    .vld_o (vf),
    .q_o   (f1)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eye0_flat[i*32 +: 32] = eye0_r[i];
      up0_flat[i*32 +: 32]  = up0_r[i];
      up1[i]                = $signed(up1_flat[i*32 +: 32]);
      f1_flat[i*FW +: FW]   = f1[i];
      f3[i]                 = $signed(f3_flat[i*FW +: FW]);
      eye3[i]               = $signed(eye3_flat[i*32 +: 32]);
    end
  end

  lav_dly #(.W(96), .N(NL)) u_eye1_dly (.clk(clk), .en(en), .d(eye0_flat), .q(eye1_flat));
  lav_dly #(.W(96), .N(NL)) u_up1_dly  (.clk(clk), .en(en), .d(up0_flat),  .q(up1_flat));

  lav_cross #(.AW(FW), .BW(32), .CW(64)) u_side_cross (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (vf),
    .a_i   (f1),
    .b_i   (up1),
    .vld_o (vc),
    .c_o   (c2)
  );

  lav_dly #(.W(3*FW), .N(CROSS_LAT)) u_f2_dly (.clk(clk), .en(en), .d(f1_flat),
                                               .q(f2_flat));
  lav_dly #(.W(96), .N(CROSS_LAT)) u_eye2_dly (.clk(clk), .en(en), .d(eye1_flat),
                                               .q(eye2_flat));

  lav_norm #(.FRAC(FRAC_BITS)) u_side_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (vc),
    .v_i   (c2),
    .vld_o (vs),
    .q_o   (s3)
  );

  lav_dly #(.W(3*FW), .N(NL)) u_f3_dly (.clk(clk), .en(en), .d(f2_flat), .q(f3_flat));
  lav_dly #(.W(96), .N(NL)) u_eye3_dly (.clk(clk), .en(en), .d(eye2_flat), .q(eye3_flat));

  lav_frame #(.FRAC(FRAC_BITS)) u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (vs),
    .s_i     (s3),
    .f_i     (f3),
    .eye_i   (eye3),
    .vld_o   (vo),
    .side_o  (side),
    .up_o    (tup),
    .back_o  (back),
    .shift_o (shift)
  );

  assign out_tvalid = vo;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_tdata[32*i +: 32]     = side[i];
      out_tdata[32*(3+i) +: 32] = tup[i];
      out_tdata[32*(6+i) +: 32] = back[i];
      out_tdata[32*(9+i) +: 32] = shift[i];
    end
  end

  assign side_x_w = $signed(out_tdata[31:0]);
  assign back_x_w = $signed(out_tdata[223:192]);

  `LAV_ASSERT_IMPL(a_side_unit, out_tvalid, side_x_w <= ONE_Q && side_x_w >= -ONE_Q, "side out of range")
  `LAV_ASSERT_IMPL(a_back_unit, out_tvalid, back_x_w <= ONE_Q && back_x_w >= -ONE_Q, "back out of range")
  `LAV_ASSERT_NEXT(a_stall_hold, !in_tready, out_tvalid && $stable(out_tdata), "stall lost result")

endmodule

/* design/lav_dly.sv */
// ----------------------------------------------------------------------------
// lav_dly
// stall-aware payload delay line
// ----------------------------------------------------------------------------
module lav_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[N-1];

endmodule

/* design/lav_cross.sv */
// ----------------------------------------------------------------------------
// lav_cross
// two-stage cross product: products registered, then differences registered
// ----------------------------------------------------------------------------
module lav_cross #(
  parameter int AW = 18,
  parameter int BW = 32,
  parameter int CW = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic signed [AW-1:0] a_i [3],
  input  logic signed [BW-1:0] b_i [3],
  output logic                 vld_o,
  output logic signed [CW-1:0] c_o [3]
);

  logic signed [AW+BW-1:0] p_r [6];
  logic signed [CW-1:0]    c_r [3];
  logic                    v1_r;
  logic                    v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= a_i[1] * b_i[2];
      p_r[1] <= a_i[2] * b_i[1];
      p_r[2] <= a_i[2] * b_i[0];
      p_r[3] <= a_i[0] * b_i[2];
      p_r[4] <= a_i[0] * b_i[1];
      p_r[5] <= a_i[1] * b_i[0];
      c_r[0] <= CW'(p_r[0]) - CW'(p_r[1]);
      c_r[1] <= CW'(p_r[2]) - CW'(p_r[3]);
      c_r[2] <= CW'(p_r[4]) - CW'(p_r[5]);
    end
  end

  assign vld_o = v2_r;
  assign c_o   = c_r;

endmodule

/* design/lav_norm.sv */
// ----------------------------------------------------------------------------
// lav_norm
// pipelined vector normalizer: scale to [2^30, 2^31), sum of squares,
// one root bit per stage, one quotient bit per stage on three lanes
// ----------------------------------------------------------------------------
module lav_norm #(
  parameter int FRAC = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   vld_i,
  input  logic signed [63:0]     v_i [3],
  output logic                   vld_o,
  output logic signed [FRAC+1:0] q_o [3]
);

  import lav_pkg::*;

  localparam int FW = FRAC + 2;
  localparam int SQ = SQRT_STEPS;
  localparam int DQ = FRAC + 1;
  localparam int NW = 32 + FRAC;
  localparam logic [FW-1:0] ONE_Q = FW'(1) << FRAC;

  // front end
  logic [63:0] m1_r [3];
  logic [2:0]  ng1_r;
  logic [63:0] big1_r;
  logic        v1_r;
  logic [63:0] m2_r [3];
  logic [2:0]  ng2_r;
  logic [5:0]  pos2_r;
  logic        zr2_r;
  logic        v2_r;
  logic [30:0] m3_r [3];
  logic [2:0]  ng3_r;
  logic        zr3_r;
  logic        v3_r;
  logic [61:0] sq4_r [3];
  logic [30:0] m4_r [3];
  logic [2:0]  ng4_r;
  logic        zr4_r;
  logic        v4_r;

  // root stages, index 0 is the sum-of-squares register
  logic [33:0] rem_r  [SQ+1];
  logic [31:0] root_r [SQ+1];
  logic [63:0] rad_r  [SQ+1];
  logic [30:0] ms_r   [SQ+1][3];
  logic [2:0]  ngs_r  [SQ+1];
  logic        zrs_r  [SQ+1];
  logic        vs_r   [SQ+1];

  // divide stages, index 0 is the numerator prep register
  logic [31:0]   drem_r [DQ+1][3];
  logic [NW-1:0] dn_r   [DQ+1][3];
  logic [DQ-1:0] dq_r   [DQ+1][3];
  logic [31:0]   dr_r   [DQ+1];
  logic [2:0]    ngd_r  [DQ+1];
  logic          zrd_r  [DQ+1];
  logic          vd_r   [DQ+1];

  logic signed [FW-1:0] q_r [3];
  logic                 vo_r;

  logic [63:0] mag_c [3];
  logic [63:0] big_c;
  logic [5:0]  pos_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = v_i[i][63] ? 64'(-v_i[i]) : 64'(v_i[i]);
    end
    big_c = mag_c[0];
    if (mag_c[1] > big_c) begin
      big_c = mag_c[1];
    end
    if (mag_c[2] > big_c) begin
      big_c = mag_c[2];
    end
    pos_c = '0;
    for (int b = 0; b < 64; b++) begin
      if (big1_r[b]) begin
        pos_c = 6'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      v4_r     <= 1'b0;
      vs_r[0]  <= 1'b0;
      vd_r[0]  <= 1'b0;
      vo_r     <= 1'b0;
    end else if (en) begin
      v1_r     <= vld_i;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      v4_r     <= v3_r;
      vs_r[0]  <= v4_r;
      vd_r[0]  <= vs_r[SQ];
      vo_r     <= vd_r[DQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1_r[i]  <= mag_c[i];
        ng1_r[i] <= v_i[i][63];
      end
      big1_r <= big_c;

      m2_r   <= m1_r;
      ng2_r  <= ng1_r;
      pos2_r <= pos_c;
      zr2_r  <= (big1_r == '0);

      for (int i = 0; i < 3; i++) begin
        if (pos2_r >= 6'd30) begin
          m3_r[i] <= 31'(m2_r[i] >> (pos2_r - 6'd30));
        end else begin
          m3_r[i] <= 31'(m2_r[i] << (6'd30 - pos2_r));
        end
      end
      ng3_r <= ng2_r;
      zr3_r <= zr2_r;

      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= m3_r[i] * m3_r[i];
      end
      m4_r  <= m3_r;
      ng4_r <= ng3_r;
      zr4_r <= zr3_r;

      rem_r[0]  <= '0;
      root_r[0] <= '0;
      rad_r[0]  <= 64'(sq4_r[0]) + 64'(sq4_r[1]) + 64'(sq4_r[2]);
      ms_r[0]   <= m4_r;
      ngs_r[0]  <= ng4_r;
      zrs_r[0]  <= zr4_r;
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_root
    logic [35:0] rn;
    logic [35:0] tr;

    always_comb begin
      rn = {rem_r[k], rad_r[k][63:62]};
      tr = {2'b00, root_r[k], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[k+1] <= 1'b0;
      end else if (en) begin
        vs_r[k+1] <= vs_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rn >= tr) begin
          rem_r[k+1]  <= 34'(rn - tr);
          root_r[k+1] <= {root_r[k][30:0], 1'b1};
        end else begin
          rem_r[k+1]  <= rn[33:0];
          root_r[k+1] <= {root_r[k][30:0], 1'b0};
        end
        rad_r[k+1] <= {rad_r[k][61:0], 2'b00};
        ms_r[k+1]  <= ms_r[k];
        ngs_r[k+1] <= ngs_r[k];
        zrs_r[k+1] <= zrs_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dn_r[0][i]   <= NW'({ms_r[SQ][i], {FRAC{1'b0}}}) + NW'(root_r[SQ][31:1]);
        drem_r[0][i] <= 32'(({ms_r[SQ][i], {FRAC{1'b0}}} + NW'(root_r[SQ][31:1]))
                            >> (FRAC + 1));
        dq_r[0][i]   <= '0;
      end
      dr_r[0]  <= root_r[SQ];
      ngd_r[0] <= ngs_r[SQ];
      zrd_r[0] <= zrs_r[SQ];
    end
  end

  for (genvar j = 0; j < DQ; j++) begin : g_div
    logic [32:0] r2 [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r2[i] = {drem_r[j][i], dn_r[j][i][FRAC-j]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[j+1] <= 1'b0;
      end else if (en) begin
        vd_r[j+1] <= vd_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (r2[i] >= {1'b0, dr_r[j]}) begin
            drem_r[j+1][i] <= 32'(r2[i] - {1'b0, dr_r[j]});
            dq_r[j+1][i]   <= {dq_r[j][i][DQ-2:0], 1'b1};
          end else begin
            drem_r[j+1][i] <= r2[i][31:0];
            dq_r[j+1][i]   <= {dq_r[j][i][DQ-2:0], 1'b0};
          end
        end
        dn_r[j+1]  <= dn_r[j];
        dr_r[j+1]  <= dr_r[j];
        ngd_r[j+1] <= ngd_r[j];
        zrd_r[j+1] <= zrd_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (zrd_r[DQ]) begin
          q_r[i] <= (i == 0) ? ONE_Q : '0;
        end else if (ngd_r[DQ][i]) begin
          q_r[i] <= -$signed(FW'(dq_r[DQ][i]));
        end else begin
          q_r[i] <= $signed(FW'(dq_r[DQ][i]));
        end
      end
    end
  end

  assign vld_o = vo_r;
  assign q_o   = q_r;

endmodule

/* design/lav_frame.sv */
// ----------------------------------------------------------------------------
// lav_frame
// true up vector, translation dot products, rounding and saturation
// ----------------------------------------------------------------------------
module lav_frame #(
  parameter int FRAC = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   vld_i,
  input  logic signed [FRAC+1:0] s_i   [3],
  input  logic signed [FRAC+1:0] f_i   [3],
  input  logic signed [31:0]     eye_i [3],
  output logic                   vld_o,
  output logic signed [31:0]     side_o  [3],
  output logic signed [31:0]     up_o    [3],
  output logic signed [31:0]     back_o  [3],
  output logic signed [31:0]     shift_o [3]
);

  import lav_pkg::*;

  localparam int FW = FRAC + 2;

  logic signed [63:0]      cu_c [3];
  logic                    v2_c;
  logic signed [FW+31:0]   ps1_r [3];
  logic signed [FW+31:0]   pf1_r [3];
  logic signed [63:0]      ds2_r;
  logic signed [63:0]      df2_r;
  logic                    v3_r;
  logic                    v4_r;
  logic                    v5_r;
  logic                    v6_r;
  logic signed [31:0]      u3_r [3];
  logic signed [31:0]      ts3_r;
  logic signed [31:0]      tf3_r;
  logic signed [63:0]      pu4_r [3];
  logic signed [31:0]      u4_r [3];
  logic signed [31:0]      ts4_r;
  logic signed [31:0]      tf4_r;
  logic signed [63:0]      du5_r;
  logic signed [31:0]      u5_r [3];
  logic signed [31:0]      ts5_r;
  logic signed [31:0]      tf5_r;
  logic signed [31:0]      side_r  [3];
  logic signed [31:0]      up_r    [3];
  logic signed [31:0]      back_r  [3];
  logic signed [31:0]      shift_r [3];

  logic [3*FW-1:0] sf_d;
  logic [3*FW-1:0] sf_q;
  logic [3*FW-1:0] ff_d;
  logic [3*FW-1:0] ff_q;
  logic [95:0]     eye_d;
  logic [95:0]     eye_q;
  logic signed [FW-1:0] s5 [3];
  logic signed [FW-1:0] f5 [3];
  logic signed [31:0]   eye3 [3];

  lav_cross #(.AW(FW), .BW(FW), .CW(64)) u_up_cross (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (vld_i),
    .a_i   (s_i),
    .b_i   (f_i),
    .vld_o (v2_c),
    .c_o   (cu_c)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sf_d[i*FW +: FW] = s_i[i];
      ff_d[i*FW +: FW] = f_i[i];
      eye_d[i*32 +: 32] = eye_i[i];
      s5[i]   = $signed(sf_q[i*FW +: FW]);
      f5[i]   = $signed(ff_q[i*FW +: FW]);
      eye3[i] = $signed(eye_q[i*32 +: 32]);
    end
  end

  lav_dly #(.W(3*FW), .N(5)) u_s_dly (.clk(clk), .en(en), .d(sf_d), .q(sf_q));
  lav_dly #(.W(3*FW), .N(5)) u_f_dly (.clk(clk), .en(en), .d(ff_d), .q(ff_q));
  lav_dly #(.W(96), .N(3)) u_eye_dly (.clk(clk), .en(en), .d(eye_d), .q(eye_q));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_c;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ps1_r[i] <= s_i[i] * eye_i[i];
        pf1_r[i] <= f_i[i] * eye_i[i];
      end
      ds2_r <= 64'(ps1_r[0]) + 64'(ps1_r[1]) + 64'(ps1_r[2]);
      df2_r <= 64'(pf1_r[0]) + 64'(pf1_r[1]) + 64'(pf1_r[2]);

      for (int i = 0; i < 3; i++) begin
        u3_r[i] <= 32'(round_fx(cu_c[i], FRAC));
      end
      ts3_r <= sat32(-round_fx(ds2_r, FRAC));
      tf3_r <= sat32(round_fx(df2_r, FRAC));

      for (int i = 0; i < 3; i++) begin
        pu4_r[i] <= u3_r[i] * eye3[i];
      end
      u4_r  <= u3_r;
      ts4_r <= ts3_r;
      tf4_r <= tf3_r;

      du5_r <= pu4_r[0] + pu4_r[1] + pu4_r[2];
      u5_r  <= u4_r;
      ts5_r <= ts4_r;
      tf5_r <= tf4_r;

      for (int i = 0; i < 3; i++) begin
        side_r[i] <= 32'(s5[i]);
        up_r[i]   <= u5_r[i];
        back_r[i] <= -32'(f5[i]);
      end
      shift_r[0] <= ts5_r;
      shift_r[1] <= sat32(-round_fx(du5_r, FRAC));
      shift_r[2] <= tf5_r;
    end
  end

  assign vld_o   = v6_r;
  assign side_o  = side_r;
  assign up_o    = up_r;
  assign back_o  = back_r;
  assign shift_o = shift_r;

endmodule
